/* hw/rtl/bfrd_pkg.sv */
// ----------------------------------------------------------------------------
// bfrd_pkg
// Shared types, constants and register codes of the black frame run detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfrd_pkg;

    localparam int FRAME_INDEX_BITS_DEF = 32;
    localparam int MAX_PIXELS_BITS_DEF  = 24;

    localparam int CHAN_W   = 8;
    localparam int THRESH_W = 16;
    localparam int PPF_W    = 25;
    localparam int OUT_W    = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = PPF_W;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_PIXELS    = CFG_INDEX_W'(1);

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = THRESH_W'(2560);
    localparam logic [PPF_W-1:0]    PIXELS_RESET    = PPF_W'(2073600);

    // BT.601 luma weights, Q14
    localparam int                    LUMA_ACC_W = 22;
    localparam int                    LUMA_SHIFT = 14;
    localparam logic [LUMA_ACC_W-1:0] LUMA_WR    = LUMA_ACC_W'(4899);
    localparam logic [LUMA_ACC_W-1:0] LUMA_WG    = LUMA_ACC_W'(9617);
    localparam logic [LUMA_ACC_W-1:0] LUMA_WB    = LUMA_ACC_W'(1868);
    localparam logic [LUMA_ACC_W-1:0] LUMA_ROUND = LUMA_ACC_W'(8192);

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_pixel;

endpackage

`default_nettype wire

/* hw/rtl/bfrd_luma.sv */
// ----------------------------------------------------------------------------
// bfrd_luma
// Gray level of one BGR pixel with rounded Q14 luma weights.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfrd_luma (
    input  wire bfrd_pkg::t_pixel           i_pix,
    output logic [bfrd_pkg::CHAN_W-1:0]     o_luma
);

    logic [bfrd_pkg::LUMA_ACC_W-1:0] acc;

    always_comb begin
        acc = bfrd_pkg::LUMA_ACC_W'(i_pix.red)   * bfrd_pkg::LUMA_WR
            + bfrd_pkg::LUMA_ACC_W'(i_pix.green) * bfrd_pkg::LUMA_WG
            + bfrd_pkg::LUMA_ACC_W'(i_pix.blue)  * bfrd_pkg::LUMA_WB
            + bfrd_pkg::LUMA_ROUND;
        o_luma = acc[bfrd_pkg::LUMA_SHIFT +: bfrd_pkg::CHAN_W];
    end

endmodule

`default_nettype wire

/* hw/rtl/black_frame_run_detector_top.sv */
// ----------------------------------------------------------------------------
// black_frame_run_detector_top
// Per-frame mean luma test on a BGR pixel stream; reports runs of black frames.
// ----------------------------------------------------------------------------
// Takes one pixel (or an end-of-video flush) per clock and runs a three-stage
// pipeline: input register, luma register, then the frame accumulator and run
// tracker, which writes the output register. A closing item passes the input
// and luma registers, and its run result is then registered at the output. The
// sustained rate is one item per clock when not stalled; the accumulate and
// threshold compare are combinational in the last stage. The pipeline stalls
// only when a frame end or flush reaches the last stage while the output
// register holds an untaken run. Config writes also reach items in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module black_frame_run_detector_top #(
    parameter int FRAME_INDEX_BITS = bfrd_pkg::FRAME_INDEX_BITS_DEF,
    parameter int MAX_PIXELS_BITS  = bfrd_pkg::MAX_PIXELS_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,

    input  wire                                 i_cfg_we,
    input  wire [bfrd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire [bfrd_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,

    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_action,
    input  wire [bfrd_pkg::CHAN_W-1:0]          i_blue,
    input  wire [bfrd_pkg::CHAN_W-1:0]          i_green,
    input  wire [bfrd_pkg::CHAN_W-1:0]          i_red,
    input  wire                                 i_frame_end,

    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [bfrd_pkg::OUT_W-1:0]          o_run_start_frame,
    output logic [bfrd_pkg::OUT_W-1:0]          o_run_end_frame
);

    localparam int SUM_W  = MAX_PIXELS_BITS + bfrd_pkg::CHAN_W;
    localparam int PROD_W = bfrd_pkg::THRESH_W + bfrd_pkg::PPF_W;
    localparam int SHL_W  = SUM_W + 8;
    localparam int CMP_W  = (SHL_W > PROD_W) ? SHL_W : PROD_W;
    localparam int EXT_W  = (FRAME_INDEX_BITS > bfrd_pkg::OUT_W) ?
                            FRAME_INDEX_BITS : bfrd_pkg::OUT_W;

    // config
    logic [bfrd_pkg::THRESH_W-1:0] r_threshold;
    logic [bfrd_pkg::PPF_W-1:0]    r_pixels;
    logic [PROD_W-1:0]             r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= bfrd_pkg::THRESHOLD_RESET;
            r_pixels    <= bfrd_pkg::PIXELS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bfrd_pkg::REG_THRESHOLD: r_threshold <= i_cfg_wdata[bfrd_pkg::THRESH_W-1:0];
                bfrd_pkg::REG_PIXELS:    r_pixels    <= i_cfg_wdata[bfrd_pkg::PPF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= PROD_W'(r_threshold) * PROD_W'(r_pixels);
    end

    // stage 1: input register
    logic                      r_s1_valid;
    logic                      r_s1_action;
    logic                      r_s1_fend;
    bfrd_pkg::t_pixel          r_s1_pix;

    // stage 2: luma register
    logic                      r_s2_valid;
    logic                      r_s2_action;
    logic                      r_s2_fend;
    logic [bfrd_pkg::CHAN_W-1:0] r_s2_luma;
    logic [bfrd_pkg::CHAN_W-1:0] s1_luma;

    // stage 3: frame and run state
    logic [SUM_W-1:0]            r_sum;
    logic [FRAME_INDEX_BITS-1:0] r_index;
    logic                        r_run_open;
    logic [FRAME_INDEX_BITS-1:0] r_run_first;
    logic [FRAME_INDEX_BITS-1:0] r_run_last;

    logic                      r_out_valid;
    logic [bfrd_pkg::OUT_W-1:0] r_out_start;
    logic [bfrd_pkg::OUT_W-1:0] r_out_end;

    logic out_free;
    logic s3_fire;
    logic s2_load;
    logic in_xfer;

    always_comb begin
        out_free   = !r_out_valid || i_out_ready;
        s3_fire    = r_s2_valid && (!(r_s2_action || r_s2_fend) || out_free);
        s2_load    = !r_s2_valid || s3_fire;
        o_in_ready = !r_s1_valid || s2_load;
        in_xfer    = i_in_valid && o_in_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_action    <= i_action;
            r_s1_fend      <= i_frame_end;
            r_s1_pix.blue  <= i_blue;
            r_s1_pix.green <= i_green;
            r_s1_pix.red   <= i_red;
        end
        if (s2_load) begin
            r_s2_action <= r_s1_action;
            r_s2_fend   <= r_s1_fend;
            r_s2_luma   <= s1_luma;
        end
    end

    bfrd_luma u_luma (
        .i_pix  (r_s1_pix),
        .o_luma (s1_luma)
    );

    // accumulate, compare, track run
    logic [SUM_W:0]              sum_add;
    logic [SUM_W-1:0]            sum_sat;
    logic                        black;
    logic                        emit;
    logic [SUM_W-1:0]            n_sum;
    logic [FRAME_INDEX_BITS-1:0] n_index;
    logic                        n_run_open;
    logic [FRAME_INDEX_BITS-1:0] n_run_first;
    logic [FRAME_INDEX_BITS-1:0] n_run_last;
    logic [EXT_W-1:0]            ext_first;
    logic [EXT_W-1:0]            ext_last;

    always_comb begin
        sum_add     = {1'b0, r_sum} + (SUM_W + 1)'(r_s2_luma);
        sum_sat     = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        black       = CMP_W'({sum_sat, 8'b0}) < CMP_W'(r_limit);
        emit        = 1'b0;
        n_sum       = r_sum;
        n_index     = r_index;
        n_run_open  = r_run_open;
        n_run_first = r_run_first;
        n_run_last  = r_run_last;
        if (r_s2_action == bfrd_pkg::ACT_FLUSH) begin
            if (r_run_open) begin
                emit       = 1'b1;
                n_run_open = 1'b0;
            end
        end else if (r_s2_fend) begin
            n_sum = '0;
            if (black) begin
                if (!r_run_open) begin
                    n_run_open  = 1'b1;
                    n_run_first = r_index;
                end
                n_run_last = r_index;
            end else if (r_run_open) begin
                emit       = 1'b1;
                n_run_open = 1'b0;
            end
            if (r_index != {FRAME_INDEX_BITS{1'b1}}) begin
                n_index = r_index + FRAME_INDEX_BITS'(1);
            end
        end else begin
            n_sum = sum_sat;
        end
        ext_first = EXT_W'(r_run_first);
        ext_last  = EXT_W'(r_run_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_index     <= '0;
            r_run_open  <= 1'b0;
            r_run_first <= '0;
            r_run_last  <= '0;
        end else if (s3_fire) begin
            r_sum       <= n_sum;
            r_index     <= n_index;
            r_run_open  <= n_run_open;
            r_run_first <= n_run_first;
            r_run_last  <= n_run_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s3_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_fire && emit) begin
            r_out_start <= ext_first[bfrd_pkg::OUT_W-1:0];
            r_out_end   <= ext_last[bfrd_pkg::OUT_W-1:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_run_start_frame = r_out_start;
    assign o_run_end_frame   = r_out_end;

endmodule

`default_nettype wire

/* hw/rtl/bfrd_checker.sv */
// ----------------------------------------------------------------------------
// bfrd_checker
// Port-level assertions for the black frame run detector, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfrd_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_out_ready,
    input wire                          o_out_valid,
    input wire [bfrd_pkg::OUT_W-1:0]    o_run_start_frame,
    input wire [bfrd_pkg::OUT_W-1:0]    o_run_end_frame
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a result must pass the input, luma and output registers after reset releases
    a_pipe_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)))
        else $error("result earlier than pipeline depth allows");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output valid dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            ($stable(o_run_start_frame) && $stable(o_run_end_frame)))
        else $error("output payload changed while stalled");

endmodule

bind black_frame_run_detector_top bfrd_checker u_bfrd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_ready       (i_out_ready),
    .o_out_valid       (o_out_valid),
    .o_run_start_frame (o_run_start_frame),
    .o_run_end_frame   (o_run_end_frame)
);

`default_nettype wire
